// ===== rtl/core/pow2_bucket_free_list_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// allocator assertion macros
// short forms for same-cycle and next-cycle implication checks
// ----------------------------------------------------------------------------
`ifndef POW2_BUCKET_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define POW2_BUCKET_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PBFLA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// consequent must hold in the cycle after the antecedent
`define PBFLA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// ===== rtl/core/pbfla_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfla_pkg
// shared constants, codes and the size-class function of the allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pbfla_pkg;

   localparam int ADDR_W    = 17;
   localparam int REQ_W     = 16;
   localparam int BUCKET_W  = 4;
   localparam int CLS_W     = 8;
   localparam int MARK_W    = 8;
   localparam int CLS_LSB   = 8;
   localparam int SH_W      = ADDR_W - 2;
   localparam int HDR_BYTES = 4;

   // refill carve is 2^REFILL_LOG bytes for classes up to SMALL_MAX
   localparam int REFILL_LOG = 11;
   localparam int SMALL_MAX  = REFILL_LOG - 3;
   localparam int WALK_W     = SMALL_MAX;

   localparam int DEF_HEAP_BYTES  = 65536;
   localparam int DEF_HEAP_BASE   = 4096;
   localparam int DEF_NUM_BUCKETS = 16;

   localparam logic [MARK_W-1:0] HDR_MARK = 8'hfd;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_GRANTED = 2'd0;
   localparam logic [1:0] STATUS_NO_MEM  = 2'd1;
   localparam logic [1:0] STATUS_FREED   = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   // size class of a request: floor(log2((n-1)>>2)), n = request+4 rounded to 4
   function automatic logic [BUCKET_W-1:0] bucket_of(input logic [REQ_W-1:0] req);
      logic [ADDR_W-1:0]   n;
      logic [SH_W-1:0]     sh;
      logic [BUCKET_W-1:0] b;
      n  = (ADDR_W'(req) + ADDR_W'(HDR_BYTES + 3)) & ~ADDR_W'(3);
      sh = SH_W'((n - ADDR_W'(1)) >> 2);
      b  = '0;
      for (int i = 1; i < SH_W; i++) begin
         if (sh[i]) begin
            b = BUCKET_W'(i);
         end
      end
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pbfla_hdr_store.sv =====
// ----------------------------------------------------------------------------
// pbfla_hdr_store
// header word memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pbfla_hdr_store #(
   parameter int DEPTH  = 8192,
   parameter int IDX_W  = 13,
   parameter int DATA_W = 17
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_idx,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]  rd_idx,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pow2_bucket_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// pow2_bucket_free_list_allocator_unit
// power-of-two size-class allocator with per-class free lists over a fixed pool
// ----------------------------------------------------------------------------
// allocate from a non-empty list: ALLOC_CHK, POP_RD, POP_WR, then the strobe;
//   a refill adds REFILL_CHK and REFILL_WR (up to 256 header writes, one per REFILL_WR step)
// free: FREE_CHK, FREE_DEC, then the strobe; FREE_CHK alone when the pointer is refused
// transactions: one at a time, next start taken in the strobe cycle
// reset: clearing pass over the HEAP_BYTES/8 header slots (8192 by
//   default) with busy high; results cannot be stalled by the receiver
`default_nettype none

module pow2_bucket_free_list_allocator_unit #(
   parameter int HEAP_BYTES  = pbfla_pkg::DEF_HEAP_BYTES,
   parameter int HEAP_BASE   = pbfla_pkg::DEF_HEAP_BASE,
   parameter int NUM_BUCKETS = pbfla_pkg::DEF_NUM_BUCKETS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_func,
   input  wire logic [pbfla_pkg::REQ_W-1:0]     req_request_bytes,
   input  wire logic [pbfla_pkg::ADDR_W-1:0]    req_block_address,
   output logic                                 rsp_strobe,
   output logic      [1:0]                      rsp_status,
   output logic      [pbfla_pkg::ADDR_W-1:0]    rsp_result_address
);

   import pbfla_pkg::*;

   // address width covers the pool end and never drops below the port width
   localparam int LIMIT  = HEAP_BASE + HEAP_BYTES;
   localparam int AW_RAW = $clog2(LIMIT + 1);
   localparam int AW     = (AW_RAW > ADDR_W) ? AW_RAW : ADDR_W;
   localparam int LW     = AW + 2;
   localparam int SLOTS  = HEAP_BYTES / 8;
   localparam int SW     = $clog2(SLOTS);
   localparam int BW     = $clog2(NUM_BUCKETS);

   localparam logic [AW-1:0]    BASE_A  = AW'(HEAP_BASE);
   localparam logic [AW-1:0]    BASE4_A = AW'(HEAP_BASE + HDR_BYTES);
   localparam logic [LW-1:0]    LIMIT_L = LW'(LIMIT);
   localparam logic [CLS_W-1:0] NB_C    = CLS_W'(NUM_BUCKETS);

   // sequencer codes
   localparam logic [3:0] ST_CLEAR      = 4'd0;
   localparam logic [3:0] ST_IDLE       = 4'd1;
   localparam logic [3:0] ST_ALLOC_CHK  = 4'd2;
   localparam logic [3:0] ST_REFILL_CHK = 4'd3;
   localparam logic [3:0] ST_REFILL_WR  = 4'd4;
   localparam logic [3:0] ST_POP_RD     = 4'd5;
   localparam logic [3:0] ST_POP_WR     = 4'd6;
   localparam logic [3:0] ST_FREE_CHK   = 4'd7;
   localparam logic [3:0] ST_FREE_DEC   = 4'd8;

   logic [3:0]          state_ff,      state_in;
   logic [AW-1:0]       heads_ff [NUM_BUCKETS];
   logic [AW-1:0]       heads_in [NUM_BUCKETS];
   logic [AW-1:0]       top_ff,        top_in;
   logic                started_ff,    started_in;
   logic [SW-1:0]       clr_ff,        clr_in;
   logic [AW-1:0]       walk_addr_ff,  walk_addr_in;
   logic [WALK_W-1:0]   walk_cnt_ff,   walk_cnt_in;
   logic [BUCKET_W-1:0] bucket_ff,     bucket_in;
   logic [AW-1:0]       cp_ff,         cp_in;
   logic                strobe_ff,     strobe_in;
   logic [1:0]          status_ff,     status_in;
   logic [ADDR_W-1:0]   result_ff,     result_in;

   // header memory port
   logic                mem_we;
   logic [SW-1:0]       mem_wr_idx;
   logic [AW-1:0]       mem_wr_data;
   logic [AW-1:0]       mem_rd_data;

   // class select and head read
   logic [CLS_W-1:0]    cls_sel;
   logic                cls_ok;
   logic [BW-1:0]       head_idx;
   logic [AW-1:0]       head_rd;

   // refill geometry of the current class
   logic                small_cls;
   logic [4:0]          blk_shift;
   logic [4:0]          carve_shift;
   logic [LW-1:0]       carve;
   logic [LW-1:0]       blk;
   logic [WALK_W:0]     count_full;
   logic [WALK_W-1:0]   walk_init;

   // shared adder and slot decoder
   logic [LW-1:0]       add_a, add_b, add_sum;
   logic [AW-1:0]       hdr;
   logic [AW-1:0]       slot_addr;
   logic [AW-1:0]       slot_off;
   logic [SW-1:0]       slot_idx;

   logic                free_reject;

   // --- class select: the header's class when deciding a free, else the request's
   always_comb begin
      if (state_ff == ST_FREE_DEC) begin
         cls_sel = mem_rd_data[CLS_LSB +: CLS_W];
      end else begin
         cls_sel = CLS_W'(bucket_ff);
      end
   end

   assign cls_ok   = cls_sel < NB_C;
   assign head_idx = cls_sel[BW-1:0];
   assign head_rd  = cls_ok ? heads_ff[head_idx] : '0;

   // --- refill geometry: 2 KiB carve for small classes, one block otherwise
   assign small_cls   = bucket_ff <= BUCKET_W'(SMALL_MAX);
   assign blk_shift   = 5'(bucket_ff) + 5'd3;
   assign carve_shift = small_cls ? 5'(REFILL_LOG) : blk_shift;
   assign carve       = LW'(1) << carve_shift;
   assign blk         = LW'(1) << blk_shift;
   assign count_full  = small_cls ? ((WALK_W + 1)'(1) << (BUCKET_W'(SMALL_MAX) - bucket_ff))
                                  : (WALK_W + 1)'(1);
   assign walk_init   = WALK_W'(count_full - (WALK_W + 1)'(1));

   // --- shared adder: carve check, walk step, user address
   always_comb begin
      case (state_ff)
         ST_REFILL_CHK: begin
            add_a = LW'(top_ff);
            add_b = carve;
         end
         ST_REFILL_WR: begin
            add_a = LW'(walk_addr_ff);
            add_b = blk;
         end
         default: begin
            add_a = LW'(head_rd);
            add_b = LW'(HDR_BYTES);
         end
      endcase
   end

   assign add_sum = add_a + add_b;

   // --- slot decoder: header address to memory index
   assign hdr = cp_ff - AW'(HDR_BYTES);

   always_comb begin
      case (state_ff)
         ST_REFILL_WR:               slot_addr = walk_addr_ff;
         ST_FREE_CHK, ST_FREE_DEC:   slot_addr = hdr;
         default:                    slot_addr = head_rd;
      endcase
   end

   assign slot_off = slot_addr - BASE_A;
   assign slot_idx = slot_off[SW+2:3];

   // free pointer checks: null, no refill yet, below the heap or past the carved top, header misaligned
   assign free_reject = (cp_ff == '0) || !started_ff || (cp_ff > top_ff) ||
                        (cp_ff < BASE4_A) || (cp_ff[2:0] != BASE4_A[2:0]);

   // --- sequencer
   always_comb begin
      state_in     = state_ff;
      heads_in     = heads_ff;
      top_in       = top_ff;
      started_in   = started_ff;
      clr_in       = clr_ff;
      walk_addr_in = walk_addr_ff;
      walk_cnt_in  = walk_cnt_ff;
      bucket_in    = bucket_ff;
      cp_in        = cp_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      result_in    = result_ff;
      mem_we       = 1'b0;
      mem_wr_idx   = slot_idx;
      mem_wr_data  = '0;

      case (state_ff)
         ST_CLEAR: begin
            // zero one header slot per step after reset, in index order
            mem_we     = 1'b1;
            mem_wr_idx = clr_ff;
            if (clr_ff == SW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SW'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               bucket_in = bucket_of(req_request_bytes);
               cp_in     = AW'(req_block_address);
               state_in  = (req_func == FUNC_FREE) ? ST_FREE_CHK : ST_ALLOC_CHK;
            end
         end

         ST_ALLOC_CHK: begin
            if (!cls_ok) begin
               strobe_in = 1'b1;
               status_in = STATUS_NO_MEM;
               result_in = '0;
               state_in  = ST_IDLE;
            end else if (head_rd == '0) begin
               state_in = ST_REFILL_CHK;
            end else begin
               state_in = ST_POP_RD;
            end
         end

         ST_REFILL_CHK: begin
            // a failed carve still marks the heap as started
            started_in = 1'b1;
            if (add_sum > LIMIT_L) begin
               strobe_in = 1'b1;
               status_in = STATUS_NO_MEM;
               result_in = '0;
               state_in  = ST_IDLE;
            end else begin
               heads_in[head_idx] = top_ff;
               top_in             = add_sum[AW-1:0];
               walk_addr_in       = top_ff;
               walk_cnt_in        = walk_init;
               state_in           = ST_REFILL_WR;
            end
         end

         ST_REFILL_WR: begin
            // link blocks in address order, the last one ends the list
            mem_we       = 1'b1;
            mem_wr_data  = (walk_cnt_ff == '0) ? '0 : add_sum[AW-1:0];
            walk_addr_in = add_sum[AW-1:0];
            if (walk_cnt_ff == '0) begin
               state_in = ST_POP_RD;
            end else begin
               walk_cnt_in = walk_cnt_ff - WALK_W'(1);
            end
         end

         ST_POP_RD: begin
            // header read of the list head is under way
            state_in = ST_POP_WR;
         end

         ST_POP_WR: begin
            heads_in[head_idx] = mem_rd_data;
            mem_we             = 1'b1;
            mem_wr_data        = AW'({bucket_ff, HDR_MARK});
            strobe_in          = 1'b1;
            status_in          = STATUS_GRANTED;
            result_in          = add_sum[ADDR_W-1:0];
            state_in           = ST_IDLE;
         end

         ST_FREE_CHK: begin
            if (free_reject) begin
               strobe_in = 1'b1;
               status_in = STATUS_IGNORED;
               result_in = '0;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_FREE_DEC;
            end
         end

         ST_FREE_DEC: begin
            strobe_in = 1'b1;
            result_in = '0;
            state_in  = ST_IDLE;
            if ((mem_rd_data[MARK_W-1:0] == HDR_MARK) && cls_ok) begin
               mem_we             = 1'b1;
               mem_wr_data        = head_rd;
               heads_in[head_idx] = hdr;
               status_in          = STATUS_FREED;
            end else begin
               status_in = STATUS_IGNORED;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         heads_ff   <= '{default: '0};
         top_ff     <= BASE_A;
         started_ff <= 1'b0;
         clr_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         heads_ff   <= heads_in;
         top_ff     <= top_in;
         started_ff <= started_in;
         clr_ff     <= clr_in;
         strobe_ff  <= strobe_in;
      end
      walk_addr_ff <= walk_addr_in;
      walk_cnt_ff  <= walk_cnt_in;
      bucket_ff    <= bucket_in;
      cp_ff        <= cp_in;
      status_ff    <= status_in;
      result_ff    <= result_in;
   end

   pbfla_hdr_store #(
      .DEPTH  (SLOTS),
      .IDX_W  (SW),
      .DATA_W (AW)
   ) u_hdr_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_idx  (mem_wr_idx),
      .wr_data (mem_wr_data),
      .rd_idx  (slot_idx),
      .rd_data (mem_rd_data)
   );

   assign busy               = state_ff != ST_IDLE;
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_address = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pbfla_checker.sv =====
// ----------------------------------------------------------------------------
// pbfla_checker
// port-level checks of the allocator's command and result channels
// ----------------------------------------------------------------------------
`default_nettype none

`include "pow2_bucket_free_list_allocator_unit_macros.svh"

module pbfla_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_strobe,
   input wire logic [1:0]                   rsp_status,
   input wire logic [pbfla_pkg::ADDR_W-1:0] rsp_result_address
);

   import pbfla_pkg::*;

   // an accepted transaction keeps the unit busy in the next cycle
   `PBFLA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // each transaction gives a single-cycle result
   `PBFLA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

   // the result comes out once the unit has gone idle
   `PBFLA_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)

   // only a grant carries an address
   `PBFLA_ASSERT_NOW(a_addr_grant, clock, reset,
      rsp_strobe && (rsp_status != STATUS_GRANTED), rsp_result_address == '0)

endmodule

bind pow2_bucket_free_list_allocator_unit pbfla_checker u_pbfla_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_status         (rsp_status),
   .rsp_result_address (rsp_result_address)
);

`default_nettype wire
